>>> src/rcd_pkg.sv
package rcd_pkg;

	localparam int MAX_ARGS_DEF    = 16;
	localparam int LENGTH_BITS_DEF = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 32;
	localparam int FIFO_DEPTH      = 4;

	localparam logic [4:0]  MAX_ARG_COUNT_RST   = 5'd16;
	localparam logic [31:0] MAX_BULK_LENGTH_RST = 32'd536870912;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_COUNT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LENGTH = 1'd1;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_NO_DOLLAR = 2'd1,
		ERR_BAD_NUM   = 2'd2,
		ERR_TOO_MANY  = 2'd3
	} rcd_err_t;

	typedef enum logic [12:0] {
		PH_IDLE      = 13'b0000000000001,
		PH_INLINE    = 13'b0000000000010,
		PH_CNT_START = 13'b0000000000100,
		PH_CNT_NEG   = 13'b0000000001000,
		PH_CNT_DIG   = 13'b0000000010000,
		PH_CNT_LF    = 13'b0000000100000,
		PH_HDR       = 13'b0000001000000,
		PH_LEN_START = 13'b0000010000000,
		PH_LEN_DIG   = 13'b0000100000000,
		PH_LEN_LF    = 13'b0001000000000,
		PH_DATA      = 13'b0010000000000,
		PH_SKIP      = 13'b0100000000000,
		PH_DISCARD   = 13'b1000000000000
	} rcd_phase_t;

	typedef struct packed {
		logic [7:0] arg_byte;
		logic       byte_valid;
		logic       arg_end;
		logic       command_end;
		logic [3:0] arg_position;
		logic [1:0] error_code;
		logic       last_of_run;
	} rcd_res_t;

	// up to two results per parsed byte
	typedef struct packed {
		logic [1:0] cnt;
		rcd_res_t   r1;
		rcd_res_t   r0;
	} rcd_push_t;

	function automatic rcd_res_t mk_res(input logic [7:0] b, input logic v, input logic ae,
			input logic ce, input logic [3:0] pos, input rcd_err_t err);
		rcd_res_t r;
		r.arg_byte     = b;
		r.byte_valid   = v;
		r.arg_end      = ae;
		r.command_end  = ce;
		r.arg_position = pos;
		r.error_code   = err;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

>>> src/rcd_ifs.sv
interface rcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface rcd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] arg_byte;
	logic       byte_valid;
	logic       arg_end;
	logic       command_end;
	logic [3:0] arg_position;
	logic [1:0] error_code;
	logic       last_of_run;

	modport source (output valid, output arg_byte, output byte_valid, output arg_end,
		output command_end, output arg_position, output error_code, output last_of_run,
		input ready);
	modport sink (input valid, input arg_byte, input byte_valid, input arg_end,
		input command_end, input arg_position, input error_code, input last_of_run,
		output ready);
endinterface

>>> src/rcd_parser.sv
module rcd_parser
	import rcd_pkg::*;
#(
	parameter int MAX_ARGS    = MAX_ARGS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rcd_byte_if.sink              data_in,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  room,
	output rcd_push_t             push
);

	localparam int CW = $clog2(MAX_ARGS + 1);
	localparam logic [35:0] LEN_MAX = 36'((64'd1 << LENGTH_BITS) - 64'd1);

	logic [7:0]  max_arg_count_q;
	logic [31:0] max_bulk_length_q;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       fire;

	rcd_phase_t             phase_q;
	logic [31:0]            num_q;
	logic [CW-1:0]          args_q;
	logic [CW-1:0]          cnt_q;
	logic [LENGTH_BITS-1:0] bytes_q;
	logic                   hcr_q, tok_q, lht_q, neg_q;

	rcd_phase_t             ph;
	logic [31:0]            num;
	logic [CW-1:0]          args;
	logic [CW-1:0]          cnt;
	logic [LENGTH_BITS-1:0] bytes;
	logic                   hcr, tok, lht, neg;

	assign fire          = v_s1 & room;
	assign data_in.ready = ~v_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_arg_count_q   <= {3'd0, MAX_ARG_COUNT_RST};
			max_bulk_length_q <= MAX_BULK_LENGTH_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MAX_ARG_COUNT)
				max_arg_count_q <= {3'd0, cfg_wdata[4:0]};
			if (cfg_index == CFG_MAX_BULK_LENGTH)
				max_bulk_length_q <= cfg_wdata[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (data_in.valid && data_in.ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_in.valid && data_in.ready)
			byte_s1 <= data_in.data_byte;
	end

	logic [31:0] lim;
	logic        is_dig;
	logic [35:0] acc10;

	always_comb begin
		lim    = (32'(max_arg_count_q) < 32'(MAX_ARGS)) ? 32'(max_arg_count_q) : 32'(MAX_ARGS);
		is_dig = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
		acc10  = 36'(num_q) * 36'd10 + 36'(byte_s1 - CH_0);
	end

	rcd_res_t   rs [2];
	logic [1:0] n;
	logic       failing;
	rcd_err_t   fcode;
	logic       run_inline;
	logic       done;

	always_comb begin
		ph = phase_q; num = num_q; args = args_q; cnt = cnt_q; bytes = bytes_q;
		hcr = hcr_q; tok = tok_q; lht = lht_q; neg = neg_q;
		rs[0] = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 4'd0, ERR_NONE);
		rs[1] = rs[0];
		n = 2'd0;
		failing = 1'b0;
		fcode = ERR_NONE;
		run_inline = 1'b0;
		done = 1'b0;

		unique case (phase_q) inside
			PH_IDLE: begin
				if (byte_s1 == CH_STAR) begin
					num = '0;
					neg = 1'b0;
					ph = PH_CNT_START;
				end else begin
					cnt = '0; tok = 1'b0; lht = 1'b0; hcr = 1'b0;
					ph = PH_INLINE;
					run_inline = 1'b1;
				end
			end
			PH_INLINE: run_inline = 1'b1;
			PH_CNT_START, PH_CNT_NEG, PH_CNT_DIG: begin
				if (phase_q == PH_CNT_START && byte_s1 == CH_MINUS) begin
					neg = 1'b1;
					ph = PH_CNT_NEG;
				end else if (is_dig) begin
					// count saturates at all ones
					num = (acc10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc10[31:0];
					ph = PH_CNT_DIG;
				end else if (phase_q == PH_CNT_DIG && byte_s1 == CH_CR) begin
					ph = PH_CNT_LF;
				end else begin
					failing = 1'b1; fcode = ERR_BAD_NUM;
				end
			end
			PH_CNT_LF: begin
				if (byte_s1 != CH_LF) begin
					failing = 1'b1; fcode = ERR_BAD_NUM;
				end else if (neg_q || num_q == 32'd0) begin
					neg = 1'b0; num = '0; ph = PH_IDLE;
				end else if (num_q > lim) begin
					failing = 1'b1; fcode = ERR_TOO_MANY;
				end else begin
					args = CW'(num_q);
					cnt = '0;
					num = '0;
					ph = PH_HDR;
				end
			end
			PH_HDR: begin
				if (byte_s1 == CH_DOLLAR) begin
					num = '0; ph = PH_LEN_START;
				end else begin
					failing = 1'b1; fcode = ERR_NO_DOLLAR;
				end
			end
			PH_LEN_START, PH_LEN_DIG: begin
				if (is_dig) begin
					if (acc10 > LEN_MAX || acc10 > {4'd0, max_bulk_length_q}) begin
						failing = 1'b1; fcode = ERR_BAD_NUM;
					end else begin
						num = acc10[31:0];
						ph = PH_LEN_DIG;
					end
				end else if (phase_q == PH_LEN_DIG && byte_s1 == CH_CR) begin
					ph = PH_LEN_LF;
				end else begin
					failing = 1'b1; fcode = ERR_BAD_NUM;
				end
			end
			PH_LEN_LF: begin
				if (byte_s1 != CH_LF) begin
					failing = 1'b1; fcode = ERR_BAD_NUM;
				end else begin
					if (num_q == 32'd0) begin
						rs[0] = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 4'(cnt_q), ERR_NONE);
						n = 2'd1;
						bytes = LENGTH_BITS'(2);
						ph = PH_SKIP;
					end else begin
						bytes = num_q[LENGTH_BITS-1:0];
						ph = PH_DATA;
					end
					num = '0;
				end
			end
			PH_DATA: begin
				rs[0] = mk_res(byte_s1, 1'b1, bytes_q <= LENGTH_BITS'(1), 1'b0, 4'(cnt_q),
					ERR_NONE);
				n = 2'd1;
				if (bytes_q <= LENGTH_BITS'(1)) begin
					bytes = LENGTH_BITS'(2);
					ph = PH_SKIP;
				end else begin
					bytes = bytes_q - LENGTH_BITS'(1);
				end
			end
			PH_SKIP: begin
				if (bytes_q > LENGTH_BITS'(1)) begin
					bytes = bytes_q - LENGTH_BITS'(1);
				end else begin
					bytes = '0;
					if (args_q <= CW'(1)) begin
						rs[0] = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 4'(cnt_q), ERR_NONE);
						n = 2'd1;
						args = '0; cnt = '0; ph = PH_IDLE;
					end else begin
						args = args_q - CW'(1);
						cnt = cnt_q + CW'(1);
						ph = PH_HDR;
					end
				end
			end
			PH_DISCARD: begin
				if (byte_s1 == CH_LF)
					ph = PH_IDLE;
			end
			default: ph = PH_IDLE;
		endcase

		if (run_inline) begin
			// a held cr is resolved by the byte after it
			if (hcr) begin
				hcr = 1'b0;
				if (byte_s1 == CH_LF) begin
					if (tok) begin
						rs[0] = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 4'(cnt), ERR_NONE);
						n = 2'd1;
					end else if (lht) begin
						rs[0] = mk_res(8'd0, 1'b0, 1'b0, 1'b1,
							4'((cnt != '0) ? cnt - CW'(1) : cnt), ERR_NONE);
						n = 2'd1;
					end
					tok = 1'b0; lht = 1'b0; cnt = '0;
					ph = PH_IDLE;
					done = 1'b1;
				end else if (!tok && 32'(cnt) >= lim) begin
					failing = 1'b1; fcode = ERR_TOO_MANY;
					done = 1'b1;
				end else begin
					tok = 1'b1; lht = 1'b1;
					rs[0] = mk_res(CH_CR, 1'b1, byte_s1 == CH_SPACE, 1'b0, 4'(cnt), ERR_NONE);
					n = 2'd1;
					if (byte_s1 == CH_SPACE) begin
						tok = 1'b0;
						cnt = cnt + CW'(1);
						done = 1'b1;
					end
				end
			end
			if (!done) begin
				if (byte_s1 == CH_CR) begin
					hcr = 1'b1;
				end else if (byte_s1 == CH_SPACE) begin
					if (tok) begin
						rs[n[0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 4'(cnt), ERR_NONE);
						n = n + 2'd1;
						tok = 1'b0;
						cnt = cnt + CW'(1);
					end
				end else if (!tok && 32'(cnt) >= lim) begin
					failing = 1'b1; fcode = ERR_TOO_MANY;
				end else begin
					tok = 1'b1; lht = 1'b1;
					rs[n[0]] = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, 4'(cnt), ERR_NONE);
					n = n + 2'd1;
				end
			end
		end

		if (failing) begin
			rs[n[0]] = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 4'(cnt), fcode);
			n = n + 2'd1;
			hcr = 1'b0; tok = 1'b0; lht = 1'b0; neg = 1'b0;
			args = '0; cnt = '0; num = '0; bytes = '0;
			ph = (byte_s1 == CH_LF) ? PH_IDLE : PH_DISCARD;
		end

		if (n != 2'd0)
			rs[n[1]].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			num_q   <= '0;
			args_q  <= '0;
			cnt_q   <= '0;
			bytes_q <= '0;
			hcr_q   <= 1'b0;
			tok_q   <= 1'b0;
			lht_q   <= 1'b0;
			neg_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= ph;
			num_q   <= num;
			args_q  <= args;
			cnt_q   <= cnt;
			bytes_q <= bytes;
			hcr_q   <= hcr;
			tok_q   <= tok;
			lht_q   <= lht;
			neg_q   <= neg;
		end
	end

	assign push.cnt = fire ? n : 2'd0;
	assign push.r0  = rs[0];
	assign push.r1  = rs[1];

endmodule

>>> src/rcd_out_fifo.sv
module rcd_out_fifo
	import rcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rcd_push_t push,
	output logic      room,
	rcd_res_if.source res_out
);

	localparam int PW = $clog2(FIFO_DEPTH);

	rcd_res_t      mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          pop;
	rcd_res_t      head;

	assign pop  = res_out.valid & res_out.ready;
	// room for two results, whatever leaves this cycle
	assign room = cnt_q <= (PW+1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wr_q + PW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push.cnt);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + (PW+1)'(push.cnt) - (PW+1)'(pop);
		end
	end

	assign head                 = mem_q[rd_q];
	assign res_out.valid        = cnt_q != '0;
	assign res_out.arg_byte     = head.arg_byte;
	assign res_out.byte_valid   = head.byte_valid;
	assign res_out.arg_end      = head.arg_end;
	assign res_out.command_end  = head.command_end;
	assign res_out.arg_position = head.arg_position;
	assign res_out.error_code   = head.error_code;
	assign res_out.last_of_run  = head.last_of_run;

endmodule

>>> src/resp_command_deframer.sv
// Request deframer for a client byte stream: RESP arrays of bulk strings and
// inline space-separated lines are cut into argument bytes with their index,
// argument-end and command-end marks, and error codes on malformed input.
// data_in: one byte per beat, valid/ready. res_out: one result per beat;
// a byte gives zero, one or two results, last_of_run marks its final one.
// cfg_we/cfg_index/cfg_wdata write max_arg_count (0) and max_bulk_length (1);
// write them only while the parser is idle.
// Throughput: one input byte per cycle as long as the result side keeps up;
// the per-byte work is one state update and one times-ten accumulate between
// the input register and a four-entry result queue.
// Each accepted byte is held in the input register and parsed from there; its
// results are then written into the queue that drives res_out.
// A byte giving two results takes two output beats; the queue absorbs this,
// and input stalls only while the queue has fewer than two free entries.
// When the receiver stalls, results wait in the queue and then data_in.ready
// falls; nothing is dropped.
// Reset clears the parser to idle, empties the queue and loads the register
// defaults (16 arguments, bulk length 2^29).
module resp_command_deframer
	import rcd_pkg::*;
#(
	parameter int MAX_ARGS    = MAX_ARGS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rcd_byte_if.sink              data_in,
	rcd_res_if.source             res_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	rcd_push_t push;
	logic      room;

	rcd_parser #(
		.MAX_ARGS    (MAX_ARGS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_in   (data_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.room      (room),
		.push      (push)
	);

	rcd_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.res_out (res_out)
	);

endmodule
